@@ src/cpdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdc_pkg: shared types and constants of the packet deframer
// Word widths, window depth, checksum seed and the header bit layout.
// ----------------------------------------------------------------------------
package cpdc_pkg;

    localparam int WORD_W     = 16;
    localparam int PKT_WORDS  = 6;
    localparam int HOLD_WORDS = PKT_WORDS - 1;
    localparam int FILL_W     = 3;
    localparam int ID_BITS    = 11;
    localparam int LEN_BITS   = 4;
    localparam int RTR_BIT    = 15;

    localparam logic [WORD_W-1:0] CSUM_SEED  = WORD_W'(1);
    localparam logic [FILL_W-1:0] FILL_EMPTY = FILL_W'(0);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(HOLD_WORDS);

    typedef logic [WORD_W-1:0] t_word;

    // a complete, checked frame as it leaves the window
    typedef struct packed {
        t_word hdr;
        t_word w1;
        t_word w2;
        t_word w3;
        t_word w4;
    } t_frame;

endpackage
`default_nettype wire

@@ src/cpdc_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdc_window: word window and checksum test
// Holds up to five earlier words, appends the new one and checks for a frame.
// ----------------------------------------------------------------------------
module cpdc_window (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire cpdc_pkg::t_word  i_word,
    output logic                  o_hit,
    output cpdc_pkg::t_frame      o_frame
);

    cpdc_pkg::t_word                 r_win [cpdc_pkg::HOLD_WORDS];
    cpdc_pkg::t_word                 n_win [cpdc_pkg::HOLD_WORDS];
    logic [cpdc_pkg::FILL_W-1:0]     r_fill;
    logic [cpdc_pkg::FILL_W-1:0]     n_fill;
    logic                            full;
    cpdc_pkg::t_word                 sum;

    // fill above five is treated as five
    assign full = (r_fill >= cpdc_pkg::FILL_FULL);

    always_comb begin
        sum = cpdc_pkg::CSUM_SEED;
        for (int i = 0; i < cpdc_pkg::HOLD_WORDS; i++) begin
            sum = cpdc_pkg::t_word'(sum + r_win[i]);
        end
    end

    assign o_hit = full && (r_win[0] != '0) && (sum == i_word);

    assign o_frame.hdr = r_win[0];
    assign o_frame.w1  = r_win[1];
    assign o_frame.w2  = r_win[2];
    assign o_frame.w3  = r_win[3];
    assign o_frame.w4  = r_win[4];

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (!full) begin
            for (int i = 0; i < cpdc_pkg::HOLD_WORDS; i++) begin
                if (r_fill == cpdc_pkg::FILL_W'(i)) begin
                    n_win[i] = i_word;
                end
            end
            n_fill = cpdc_pkg::FILL_W'(r_fill + 1'b1);
        end else if (o_hit) begin
            // frame taken: window starts afresh
            for (int i = 0; i < cpdc_pkg::HOLD_WORDS; i++) begin
                n_win[i] = '0;
            end
            n_fill = cpdc_pkg::FILL_EMPTY;
        end else begin
            // drop the head word only
            for (int i = 0; i < cpdc_pkg::HOLD_WORDS - 1; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_win[cpdc_pkg::HOLD_WORDS-1] = i_word;
            n_fill = cpdc_pkg::FILL_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= cpdc_pkg::FILL_EMPTY;
            for (int i = 0; i < cpdc_pkg::HOLD_WORDS; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_fire) begin
            r_fill <= n_fill;
            r_win  <= n_win;
        end
    end

endmodule
`default_nettype wire

@@ src/cpdc_frame_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdc_frame_reg: result register
// Splits the header into its fields and holds the frame until it is taken.
// ----------------------------------------------------------------------------
module cpdc_frame_reg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire logic                            i_hit,
    input  wire cpdc_pkg::t_frame                i_frame,
    input  wire logic                            i_stall,
    output logic                                 o_valid,
    output logic [cpdc_pkg::ID_BITS-1:0]         o_can_id,
    output logic [cpdc_pkg::LEN_BITS-1:0]        o_length_code,
    output logic                                 o_remote_request,
    output cpdc_pkg::t_word                      o_payload_half_1,
    output cpdc_pkg::t_word                      o_payload_half_2,
    output cpdc_pkg::t_word                      o_payload_half_3,
    output cpdc_pkg::t_word                      o_payload_half_4
);

    logic r_valid;
    logic free;

    assign free    = !r_valid || !i_stall;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= i_load && i_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && i_load && i_hit) begin
            o_can_id         <= i_frame.hdr[cpdc_pkg::ID_BITS-1:0];
            o_length_code    <= ~i_frame.hdr[cpdc_pkg::RTR_BIT-1:cpdc_pkg::ID_BITS];
            o_remote_request <= i_frame.hdr[cpdc_pkg::RTR_BIT];
            o_payload_half_1 <= i_frame.w2;
            o_payload_half_2 <= i_frame.w1;
            o_payload_half_3 <= i_frame.w4;
            o_payload_half_4 <= i_frame.w3;
        end
    end

endmodule
`default_nettype wire

@@ src/can_packet_deframer_checksum_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_packet_deframer_checksum_core: serial half-word to frame deframer
// Finds six-word frames with a nonzero header and a checksum word in a
// stream of 16-bit words and emits the parsed frame.
// ----------------------------------------------------------------------------
// One received word is taken per clock cycle when the output side keeps up.
// A word waits in the input register, then the window logic appends
// it, forms 1 plus the wrapping sum of the five held words and compares it
// with the new word combinationally; that adder chain and compare set the
// clock. A frame is loaded into the result register at the edge where its
// checksum word leaves the input register. Words that do not end a frame
// produce no output transaction. When a frame waits on a stalled output,
// the input register still takes one more word, then o_stall rises until
// the frame is taken.
// ----------------------------------------------------------------------------
module can_packet_deframer_checksum_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // received word transactions
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire cpdc_pkg::t_word                 i_rx_word,
    // frame transactions
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [cpdc_pkg::ID_BITS-1:0]         o_can_id,
    output logic [cpdc_pkg::LEN_BITS-1:0]        o_length_code,
    output logic                                 o_remote_request,
    output cpdc_pkg::t_word                      o_payload_half_1,
    output cpdc_pkg::t_word                      o_payload_half_2,
    output cpdc_pkg::t_word                      o_payload_half_3,
    output cpdc_pkg::t_word                      o_payload_half_4
);

    // input register
    logic               r_in_valid;
    cpdc_pkg::t_word    r_in_word;

    logic               out_free;   // result register can take a new frame
    logic               fire;       // the held word is processed this cycle
    logic               in_take;    // a word transaction completes
    logic               hit;
    cpdc_pkg::t_frame   frame;

    assign out_free = !o_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    // input register frees up when its word moves on
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_rx_word;
        end
    end

    // window, checksum and frame decision
    cpdc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in_word),
        .o_hit   (hit),
        .o_frame (frame)
    );

    // field split and result register
    cpdc_frame_reg u_frame_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (fire),
        .i_hit            (hit),
        .i_frame          (frame),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_can_id         (o_can_id),
        .o_length_code    (o_length_code),
        .o_remote_request (o_remote_request),
        .o_payload_half_1 (o_payload_half_1),
        .o_payload_half_2 (o_payload_half_2),
        .o_payload_half_3 (o_payload_half_3),
        .o_payload_half_4 (o_payload_half_4)
    );

endmodule
`default_nettype wire

@@ src/cpdc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdc_checker: port checks for the deframer
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module cpdc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic                            o_stall,
    input  wire cpdc_pkg::t_word                 i_rx_word,
    input  wire logic                            o_valid,
    input  wire logic                            i_stall,
    input  wire logic [cpdc_pkg::ID_BITS-1:0]    o_can_id,
    input  wire logic [cpdc_pkg::LEN_BITS-1:0]   o_length_code,
    input  wire logic                            o_remote_request,
    input  wire cpdc_pkg::t_word                 o_payload_half_1,
    input  wire cpdc_pkg::t_word                 o_payload_half_2,
    input  wire cpdc_pkg::t_word                 o_payload_half_3,
    input  wire cpdc_pkg::t_word                 o_payload_half_4
);

    // no frame straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("frame valid after reset");

    // back-pressure on the input only while a frame is held up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked frame");

    // a zero header never yields a frame
    a_hdr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_can_id != '0 || o_length_code != '1 || o_remote_request))
        else $error("frame with zero header");

    // a stalled frame holds
    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_can_id)
            && $stable(o_length_code) && $stable(o_remote_request)
            && $stable(o_payload_half_1) && $stable(o_payload_half_2)
            && $stable(o_payload_half_3) && $stable(o_payload_half_4)))
        else $error("stalled frame changed");

endmodule

bind can_packet_deframer_checksum_core cpdc_checker u_checker (.*);
`default_nettype wire

@@ sim/cpdc_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdc_frame_checker: frame predictor and scoreboard for the deframer
// Watches the received word and frame channels, keeps its own word window
// and compares every frame transaction with the oldest predicted frame.
// ----------------------------------------------------------------------------
module cpdc_frame_checker
    import cpdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // received word channel
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  t_word                      i_rx_word,
    // frame channel
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [ID_BITS-1:0]    i_can_id,
    input  wire logic [LEN_BITS-1:0]   i_length_code,
    input  wire logic                  i_remote_request,
    input  t_word                      i_payload_half_1,
    input  t_word                      i_payload_half_2,
    input  t_word                      i_payload_half_3,
    input  t_word                      i_payload_half_4,
    // status towards the testbench top
    output int                         o_fail_count,
    output int                         o_frames_pending
);

    typedef struct packed {
        logic [ID_BITS-1:0]  can_id;
        logic [LEN_BITS-1:0] length_code;
        logic                remote_request;
        t_word               half_1;
        t_word               half_2;
        t_word               half_3;
        t_word               half_4;
    } t_frame_fields;

    t_word              held_words [HOLD_WORDS];
    logic [FILL_W-1:0]  held_fill;
    t_frame_fields      frames_due [$];
    int                 fail_tally;

    initial begin
        o_fail_count     = 0;
        o_frames_pending = 0;
        fail_tally       = 0;
        held_fill        = FILL_EMPTY;
    end

    // append one word, look for a complete frame at the window head
    function automatic void shift_in_word(input t_word w, output bit found,
                                          output t_frame_fields frame);
        t_word seq [PKT_WORDS];
        int    n;
        t_word sum;
        found = 1'b0;
        frame = '0;
        n     = int'(held_fill);
        for (int i = 0; i < n; i++) seq[i] = held_words[i];
        seq[n] = w;
        n++;
        if (n < PKT_WORDS) begin
            for (int i = 0; i < n; i++) held_words[i] = seq[i];
            held_fill = FILL_W'(n);
            return;
        end
        sum = CSUM_SEED;
        for (int i = 0; i < HOLD_WORDS; i++) sum = sum + seq[i];
        if (seq[0] != '0 && sum == seq[HOLD_WORDS]) begin
            found                = 1'b1;
            frame.can_id         = seq[0][ID_BITS-1:0];
            frame.length_code    = ~seq[0][ID_BITS+LEN_BITS-1:ID_BITS];
            frame.remote_request = seq[0][RTR_BIT];
            frame.half_1         = seq[2];
            frame.half_2         = seq[1];
            frame.half_3         = seq[4];
            frame.half_4         = seq[3];
            for (int i = 0; i < HOLD_WORDS; i++) held_words[i] = '0;
            held_fill = FILL_EMPTY;
        end else begin
            // zero header or bad checksum: only the head goes
            for (int i = 0; i < HOLD_WORDS; i++) held_words[i] = seq[i+1];
            held_fill = FILL_FULL;
        end
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_fields due;
        t_frame_fields made;
        bit            found;
        if (!i_rst_n) begin
            for (int i = 0; i < HOLD_WORDS; i++) held_words[i] = '0;
            held_fill = FILL_EMPTY;
            frames_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame, expected none actual id %h len %h rtr %b",
                             $time, i_can_id, i_length_code, i_remote_request);
                    fail_tally++;
                end else begin
                    due = frames_due.pop_front();
                    check_field("can_id", WORD_W'(due.can_id), WORD_W'(i_can_id));
                    check_field("length_code", WORD_W'(due.length_code),
                                WORD_W'(i_length_code));
                    check_field("remote_request", WORD_W'(due.remote_request),
                                WORD_W'(i_remote_request));
                    check_field("payload_half_1", due.half_1, i_payload_half_1);
                    check_field("payload_half_2", due.half_2, i_payload_half_2);
                    check_field("payload_half_3", due.half_3, i_payload_half_3);
                    check_field("payload_half_4", due.half_4, i_payload_half_4);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                shift_in_word(i_rx_word, found, made);
                if (found) frames_due.push_back(made);
            end
        end
        o_fail_count     <= fail_tally;
        o_frames_pending <= frames_due.size();
    end

endmodule

@@ sim/tb_can_packet_deframer_checksum_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_packet_deframer_checksum_core: stimulus and verdict for the deframer
// Sends directed and random word streams in bursts against a stalling frame
// receiver; a side checker predicts every frame and counts mismatches.
// ----------------------------------------------------------------------------
module tb_can_packet_deframer_checksum_core;
    import cpdc_pkg::*;

    localparam int RANDOM_WORDS = 400;
    localparam int DRAIN_CYCLES = 10;
    // receiver hold-off window, in cycles after reset release
    localparam int HOLD_START   = 150;
    localparam int HOLD_CYCLES  = 200;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    t_word                i_rx_word = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [ID_BITS-1:0]   o_can_id;
    logic [LEN_BITS-1:0]  o_length_code;
    logic                 o_remote_request;
    t_word                o_payload_half_1;
    t_word                o_payload_half_2;
    t_word                o_payload_half_3;
    t_word                o_payload_half_4;

    int                   fail_count;
    int                   frames_pending;
    int                   words_sent = 0;
    int                   burst_left = 0;

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    can_packet_deframer_checksum_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_word        (i_rx_word),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_can_id         (o_can_id),
        .o_length_code    (o_length_code),
        .o_remote_request (o_remote_request),
        .o_payload_half_1 (o_payload_half_1),
        .o_payload_half_2 (o_payload_half_2),
        .o_payload_half_3 (o_payload_half_3),
        .o_payload_half_4 (o_payload_half_4)
    );

    cpdc_frame_checker u_frame_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_rx_word        (i_rx_word),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_can_id         (o_can_id),
        .i_length_code    (o_length_code),
        .i_remote_request (o_remote_request),
        .i_payload_half_1 (o_payload_half_1),
        .i_payload_half_2 (o_payload_half_2),
        .i_payload_half_3 (o_payload_half_3),
        .i_payload_half_4 (o_payload_half_4),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending)
    );

    // checksum word that closes a frame: seed plus wrapping sum of five words
    function automatic t_word frame_checksum(input t_word hdr, input t_word w1,
                                             input t_word w2, input t_word w3,
                                             input t_word w4);
        return CSUM_SEED + hdr + w1 + w2 + w3 + w4;
    endfunction

    // payload words lean towards the extremes now and then
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return t_word'($urandom());
        endcase
    endfunction

    // one word transaction; called and returning at a falling edge
    task automatic send_word(input t_word w);
        if (burst_left == 0) begin
            // gap between bursts, then a fresh burst length
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
        end
        i_valid   <= 1'b1;
        i_rx_word <= w;
        // held steady until the block takes it
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        burst_left--;
        words_sent++;
    endtask

    // six words: header, four payload words, checksum with optional damage
    task automatic send_frame(input t_word hdr, input t_word w1, input t_word w2,
                              input t_word w3, input t_word w4, input t_word damage);
        send_word(hdr);
        send_word(w1);
        send_word(w2);
        send_word(w3);
        send_word(w4);
        send_word(frame_checksum(hdr, w1, w2, w3, w4) ^ damage);
    endtask

    // receiver: stall modes in random segments, plus one long hold-off
    initial begin
        int cycle;
        int mode;
        int seg_len;
        int period;
        cycle = 0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 80);
            period  = $urandom_range(2, 5);
            repeat (seg_len) begin
                if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
                    // long hold-off so that frames back up into the input side
                    i_stall <= 1'b1;
                end else begin
                    case (mode)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= $urandom_range(0, 2) == 0;
                        2:       i_stall <= (cycle % period) == 0;
                        default: i_stall <= $urandom_range(0, 3) != 0;
                    endcase
                end
                @(negedge i_clk);
                cycle++;
            end
        end
    end

    // sender and verdict
    initial begin
        int kind;
        t_word hdr;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all-ones header: widest id, zero length code, remote request set
        send_frame('1, '1, '1, '1, '1, '0);
        // lowest nonzero header with distinct payload words to pin the order
        send_frame(16'h0001, 16'h1111, 16'h2222, 16'h3333, 16'h4444, '0);
        // zero header with a correct checksum is not a frame
        send_frame('0, 16'h00aa, 16'h5500, 16'h0f0f, 16'hf0f0, '0);
        // broken checksum on an otherwise valid frame
        send_frame(16'h8000, 16'hdead, 16'hbeef, 16'hcafe, 16'hf00d, 16'h0001);

        // random part: mostly good frames, some broken ones and noise
        while (words_sent < RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                hdr = $urandom_range(0, 7) == 0 ? t_word'(16'h8000)
                                                : t_word'($urandom_range(1, 65535));
                send_frame(hdr, pick_word(), pick_word(), pick_word(), pick_word(), '0);
            end else if (kind < 80) begin
                send_frame(t_word'($urandom_range(1, 65535)), pick_word(), pick_word(),
                           pick_word(), pick_word(), t_word'($urandom_range(1, 65535)));
            end else if (kind < 88) begin
                send_frame('0, pick_word(), pick_word(), pick_word(), pick_word(), '0);
            end else begin
                repeat ($urandom_range(1, 3)) send_word(pick_word());
            end
        end

        i_valid <= 1'b0;
        // wait for the last predicted frame, then let the pipeline settle
        while (frames_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
